// ===== hw/rtl/dze_pkg.sv =====
// ----------------------------------------------------------------------------
// dze_pkg: shared types and helpers for the delta zigzag entry encoder
// Field widths, stage payload types, zigzag mapping and byte counting.
// ----------------------------------------------------------------------------
package dze_pkg;

   localparam int FIELD_COUNT = 3;
   localparam int WORD_W      = 64;
   localparam int BYTE_W      = 8;
   localparam int CNT_W       = 4;
   localparam int LEN_W       = 5;
   localparam int BYTE_SEL_W  = 3;
   localparam int FIELD_SEL_W = 2;

   typedef logic [FIELD_COUNT-1:0][WORD_W-1:0] word_set_type;
   typedef logic [FIELD_COUNT-1:0][CNT_W-1:0]  cnt_set_type;

   // An encoded entry as it travels into the byte serializer.
   typedef struct packed {
      word_set_type      enc;
      cnt_set_type       cnt;
      logic [LEN_W-1:0]  total;
   } zz_item_type;

   // Zigzag: move the sign into bit 0 so small magnitudes stay small.
   function automatic logic [WORD_W-1:0] zigzag(input logic [WORD_W-1:0] d);
      return {d[WORD_W-2:0], 1'b0} ^ {WORD_W{d[WORD_W-1]}};
   endfunction

   // Number of bytes up to and including the highest nonzero byte.
   function automatic logic [CNT_W-1:0] byte_count(input logic [WORD_W-1:0] v);
      logic [CNT_W-1:0] c;
      c = '0;
      for (int i = 0; i < WORD_W / BYTE_W; i++) begin
         if (|v[i*BYTE_W +: BYTE_W]) begin
            c = CNT_W'(i + 1);
         end
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/dze_delta.sv =====
// ----------------------------------------------------------------------------
// dze_delta: difference stage
// Registers the three wrapping 64-bit differences of new minus previous.
// ----------------------------------------------------------------------------
module dze_delta
   import dze_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  word_set_type new_set,
   input  word_set_type prev_set,
   output logic         out_valid,
   input  logic         out_ready,
   output word_set_type out_diff
);

   logic         valid_ff, valid_in;
   word_set_type diff_ff, diff_in;

   always_comb begin
      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
      diff_in  = diff_ff;
      if (in_valid && in_ready) begin
         for (int i = 0; i < FIELD_COUNT; i++) begin
            diff_in[i] = new_set[i] - prev_set[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      diff_ff <= diff_in;
   end

   assign out_valid = valid_ff;
   assign out_diff  = diff_ff;

endmodule

// ===== hw/rtl/dze_zigzag.sv =====
// ----------------------------------------------------------------------------
// dze_zigzag: zigzag and length stage
// Zigzag-encodes each difference and registers its byte count and the total.
// ----------------------------------------------------------------------------
module dze_zigzag
   import dze_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  word_set_type in_diff,
   output logic         out_valid,
   input  logic         out_ready,
   output zz_item_type  out_item
);

   logic        valid_ff, valid_in;
   zz_item_type item_ff, item_in;
   logic [LEN_W-1:0] total;

   always_comb begin
      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
      item_in  = item_ff;
      total    = LEN_W'(2);
      if (in_valid && in_ready) begin
         for (int i = 0; i < FIELD_COUNT; i++) begin
            item_in.enc[i] = zigzag(in_diff[i]);
            item_in.cnt[i] = byte_count(item_in.enc[i]);
            total          = total + LEN_W'(item_in.cnt[i]);
         end
         item_in.total = total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== hw/rtl/dze_serial.sv =====
// ----------------------------------------------------------------------------
// dze_serial: byte serializer
// Emits the two header bytes and then the counted bytes of each field.
// ----------------------------------------------------------------------------
module dze_serial
   import dze_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  zz_item_type       in_item,
   output logic              out_valid,
   input  logic              out_stall,
   output logic [BYTE_W-1:0] out_byte,
   output logic              out_last
);

   typedef enum logic [1:0] {
      HDR_LO,
      HDR_HI,
      BODY
   } phase_type;

   logic                   busy_ff, busy_in;
   phase_type              phase_ff, phase_in;
   logic [FIELD_SEL_W-1:0] fld_ff, fld_in;
   logic [BYTE_SEL_W-1:0]  byt_ff, byt_in;
   logic [LEN_W-1:0]       rem_ff, rem_in;
   zz_item_type            item_ff, item_in;
   logic                   out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]      out_byte_ff, out_byte_in;
   logic                   out_last_ff, out_last_in;

   logic              out_upd, emit, is_last, load;
   logic [BYTE_W-1:0] byte_cur;

   // First field at or after 'from' that has any bytes to send.
   function automatic logic [FIELD_SEL_W-1:0] next_field(
      input cnt_set_type            cnt,
      input logic [FIELD_SEL_W:0]   from
   );
      logic [FIELD_SEL_W-1:0] res;
      res = '0;
      for (int i = FIELD_COUNT - 1; i >= 0; i--) begin
         if ((FIELD_SEL_W + 1)'(i) >= from && cnt[i] != '0) begin
            res = FIELD_SEL_W'(i);
         end
      end
      return res;
   endfunction

   always_comb begin
      out_upd  = !out_valid_ff || !out_stall;
      emit     = busy_ff && out_upd;
      is_last  = (rem_ff == LEN_W'(1));
      in_ready = !busy_ff || (emit && is_last);
      load     = in_valid && in_ready;

      case (phase_ff)
         HDR_LO:  byte_cur = {item_ff.cnt[1], item_ff.cnt[0]};
         HDR_HI:  byte_cur = {{(BYTE_W - CNT_W){1'b0}}, item_ff.cnt[2]};
         default: byte_cur = item_ff.enc[fld_ff][{byt_ff, 3'b000} +: BYTE_W];
      endcase

      busy_in  = busy_ff;
      phase_in = phase_ff;
      fld_in   = fld_ff;
      byt_in   = byt_ff;
      rem_in   = rem_ff;
      item_in  = item_ff;

      if (emit) begin
         rem_in = rem_ff - LEN_W'(1);
         unique case (phase_ff)
            HDR_LO: begin
               phase_in = HDR_HI;
            end
            HDR_HI: begin
               phase_in = BODY;
               fld_in   = next_field(item_ff.cnt, '0);
               byt_in   = '0;
            end
            default: begin
               if (CNT_W'(byt_ff) + CNT_W'(1) == item_ff.cnt[fld_ff]) begin
                  fld_in = next_field(item_ff.cnt,
                                      {1'b0, fld_ff} + (FIELD_SEL_W + 1)'(1));
                  byt_in = '0;
               end else begin
                  byt_in = byt_ff + BYTE_SEL_W'(1);
               end
            end
         endcase
         if (is_last) begin
            busy_in = 1'b0;
         end
      end

      if (load) begin
         item_in  = in_item;
         busy_in  = 1'b1;
         phase_in = HDR_LO;
         rem_in   = in_item.total;
         fld_in   = '0;
         byt_in   = '0;
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (out_upd) begin
         out_valid_in = busy_ff;
         out_byte_in  = byte_cur;
         out_last_in  = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= HDR_LO;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
      fld_ff      <= fld_in;
      byt_ff      <= byt_in;
      rem_ff      <= rem_in;
      item_ff     <= item_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;

endmodule

// ===== hw/rtl/delta_zigzag_entry_encoder.sv =====
// ----------------------------------------------------------------------------
// delta_zigzag_entry_encoder: delta, zigzag and group-length entry encoder
// Path: an accepted item is registered by dze_delta, dze_zigzag and the
// serializer in turn, and its bytes then pass through an output register.
// Length: 2 + (sum of field byte counts) bytes per item, 2 to 26.
// Reset: synchronous; empties every stage and drops any item in flight.
// ----------------------------------------------------------------------------
//
// Each input item is a new search entry and the entry before it. The block
// subtracts each field of the previous entry from the new one (wrapping at
// 64 bits), zigzag-encodes the difference, and counts its low bytes up to
// the highest nonzero byte. The result is a byte stream: a little-endian 16-bit
// header with one byte count per nibble (hash, inode, id, top nibble zero),
// followed by the counted bytes of each field, least significant first.
//
// Pipeline:
//   stage 1 (dze_delta)  - three 64-bit subtractions.
//   stage 2 (dze_zigzag) - zigzag mapping, byte counts and total length.
//   stage 3 (dze_serial) - holds one encoded item and walks through its
//                          bytes, one per cycle while the output is not stalled, into an output register.
// Every stage has its own valid bit and moves forward whenever the stage
// after it is empty or handing on, so the first two stages fill with the
// next items while the serializer is busy or the output register is stalled.
module delta_zigzag_entry_encoder
   import dze_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [WORD_W-1:0] req_new_hash,
   input  logic [WORD_W-1:0] req_new_inode,
   input  logic [WORD_W-1:0] req_new_ident,
   input  logic [WORD_W-1:0] req_prev_hash,
   input  logic [WORD_W-1:0] req_prev_inode,
   input  logic [WORD_W-1:0] req_prev_ident,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_last_byte
);

   // Field order inside the packed sets is hash, inode, id from index 0 up,
   // which is also the order of the header nibbles and of the body bytes.
   word_set_type new_set, prev_set, diff;
   zz_item_type  zz_item;
   logic         req_ready;
   logic         diff_valid, diff_ready;
   logic         zz_valid, zz_ready;

   assign new_set  = {req_new_ident, req_new_inode, req_new_hash};
   assign prev_set = {req_prev_ident, req_prev_inode, req_prev_hash};

   dze_delta u_delta (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .new_set   (new_set),
      .prev_set  (prev_set),
      .out_valid (diff_valid),
      .out_ready (diff_ready),
      .out_diff  (diff)
   );

   dze_zigzag u_zigzag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (diff_valid),
      .in_ready  (diff_ready),
      .in_diff   (diff),
      .out_valid (zz_valid),
      .out_ready (zz_ready),
      .out_item  (zz_item)
   );

   // The serializer takes a new item in the same cycle that the last byte
   // of the current one moves into the output register.
   dze_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (zz_valid),
      .in_ready  (zz_ready),
      .in_item   (zz_item),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_byte  (rsp_out_byte),
      .out_last  (rsp_last_byte)
   );

   assign req_stall = !req_ready;

endmodule

// ===== hw/rtl/dze_check.sv =====
// ----------------------------------------------------------------------------
// dze_check: port checker for the entry encoder
// Watches the result byte stream framing and the output handshake.
// ----------------------------------------------------------------------------
module dze_check
   import dze_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input logic              rsp_last_byte
);

   // Position of the current byte within its item's encoding.
   logic [LEN_W-1:0] pos_ff, pos_in;

   always_comb begin
      pos_in = pos_ff;
      if (rsp_valid && !rsp_stall) begin
         pos_in = rsp_last_byte ? '0 : pos_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
                                 && $stable(rsp_last_byte))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_header_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pos_ff == '0 |-> !rsp_last_byte)
      else $error("item ended inside its header");

   a_header_top_nibble: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pos_ff == LEN_W'(1) |-> rsp_out_byte[7:4] == 4'h0)
      else $error("header top nibble not zero");

   a_max_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pos_ff <= LEN_W'(25))
      else $error("item longer than 26 bytes");

endmodule

bind delta_zigzag_entry_encoder dze_check u_dze_check (.*);
